// ===== sv/ppc_pkg.sv =====
// ---------------------------------------------------------------------------
// ppc_pkg
// Shared types and constants of the perspective projection and clip unit.
// ---------------------------------------------------------------------------
package ppc_pkg;

  localparam int unsigned FRAC_W  = 16;  // fraction bits of Q16.16
  localparam int unsigned POS_W   = 32;  // camera-space coordinate width
  localparam int unsigned FOCAL_W = 32;  // focal factor width
  localparam int unsigned WIN_W   = 13;  // window size register width
  localparam int unsigned OUT_W   = 15;  // screen coordinate width
  localparam int unsigned PROD_W  = 63;  // width of focal * |pos|
  localparam int unsigned DEN_W   = 31;  // width of a positive depth
  localparam int unsigned QUO_W   = 42;  // quotient bits produced by the cells
  localparam int unsigned SAT_BIT = 40;  // quotients from 2^40 up are hidden
  localparam int unsigned SUM_W   = 43;  // signed width of centre plus offset
  localparam int unsigned DATA_W  = 32;  // configuration data width
  localparam int unsigned ADDR_W  = 4;   // configuration address width

  localparam logic [WIN_W-1:0]   WIN_W_RST   = WIN_W'(800);
  localparam logic [WIN_W-1:0]   WIN_H_RST   = WIN_W'(600);
  localparam logic [FOCAL_W-1:0] FOCAL_X_RST = FOCAL_W'(26214400);
  localparam logic [FOCAL_W-1:0] FOCAL_Y_RST = FOCAL_W'(19660800);

  typedef enum logic [1:0] {
    REG_WIN_WIDTH  = 2'd0,
    REG_WIN_HEIGHT = 2'd1,
    REG_FOCAL_X    = 2'd2,
    REG_FOCAL_Y    = 2'd3
  } ppc_reg_e;

  // One axis of the division: partial remainder, dividend bits still to be
  // consumed, quotient bits produced so far, and the sign of the position.
  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] dvd;
    logic [QUO_W-1:0] quo;
  } ppc_lane_t;

  // The word handed from cell to cell.
  typedef struct packed {
    logic             live;
    logic [DEN_W-1:0] den;
    ppc_lane_t        lx;
    ppc_lane_t        ly;
  } ppc_word_t;

endpackage

// ===== sv/ppc_vtx_if.sv =====
// ---------------------------------------------------------------------------
// ppc_vtx_if
// Vertex channel: one camera-space vertex per word.
// ---------------------------------------------------------------------------
interface ppc_vtx_if import ppc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

// ===== sv/ppc_pix_if.sv =====
// ---------------------------------------------------------------------------
// ppc_pix_if
// Pixel channel: one projected point per word.
// ---------------------------------------------------------------------------
interface ppc_pix_if import ppc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] screen_x;
  logic signed [OUT_W-1:0] screen_y;
  logic                    visible;

  modport source (output valid, output screen_x, output screen_y, output visible,
                  input ready);
  modport sink   (input valid, input screen_x, input screen_y, input visible,
                  output ready);
endinterface

// ===== sv/ppc_front.sv =====
// ---------------------------------------------------------------------------
// ppc_front
// Input register, the two focal multipliers and the divider seed stage.
// ---------------------------------------------------------------------------
module ppc_front import ppc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic signed [POS_W-1:0]   pos_x_i,
  input  logic signed [POS_W-1:0]   pos_y_i,
  input  logic signed [POS_W-1:0]   pos_z_i,
  input  logic        [FOCAL_W-1:0] focal_x_i,
  input  logic        [FOCAL_W-1:0] focal_y_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output ppc_word_t                 word_o
);

  typedef struct packed {
    logic             live;
    logic             neg_x;
    logic             neg_y;
    logic [POS_W-1:0] mag_x;
    logic [POS_W-1:0] mag_y;
    logic [DEN_W-1:0] den;
  } ppc_mag_t;

  typedef struct packed {
    logic              live;
    logic              neg_x;
    logic              neg_y;
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;
    logic [DEN_W-1:0]  den;
  } ppc_prod_t;

  logic      mag_v_q, prod_v_q, seed_v_q;
  logic      mag_rdy, prod_rdy, seed_rdy;
  ppc_mag_t  mag_d, mag_q;
  ppc_prod_t prod_d, prod_q;
  ppc_word_t seed_d, seed_q;
  logic [2*FOCAL_W-1:0] mul_x, mul_y;
  logic [DEN_W-1:0]     top_x, top_y;

  assign seed_rdy = !seed_v_q || ready_i;
  assign prod_rdy = !prod_v_q || seed_rdy;
  assign mag_rdy  = !mag_v_q  || prod_rdy;
  assign ready_o  = mag_rdy;

  // Magnitudes; the most negative position gives 2^31, which still fits.
  always_comb begin
    mag_d.live  = !pos_z_i[POS_W-1] && (pos_z_i != '0);
    mag_d.neg_x = pos_x_i[POS_W-1];
    mag_d.neg_y = pos_y_i[POS_W-1];
    mag_d.mag_x = pos_x_i[POS_W-1] ? POS_W'(-pos_x_i) : POS_W'(pos_x_i);
    mag_d.mag_y = pos_y_i[POS_W-1] ? POS_W'(-pos_y_i) : POS_W'(pos_y_i);
    mag_d.den   = pos_z_i[DEN_W-1:0];
  end

  assign mul_x = focal_x_i * mag_q.mag_x;
  assign mul_y = focal_y_i * mag_q.mag_y;

  always_comb begin
    prod_d.live   = mag_q.live;
    prod_d.neg_x  = mag_q.neg_x;
    prod_d.neg_y  = mag_q.neg_y;
    prod_d.prod_x = mul_x[PROD_W-1:0];
    prod_d.prod_y = mul_y[PROD_W-1:0];
    prod_d.den    = mag_q.den;
  end

  // A quotient of 2^42 or more is flagged here; the remainder seed is
  // then below the divisor, as each cell expects.
  assign top_x = DEN_W'(prod_q.prod_x[PROD_W-1:QUO_W]);
  assign top_y = DEN_W'(prod_q.prod_y[PROD_W-1:QUO_W]);

  always_comb begin
    seed_d.live   = prod_q.live;
    seed_d.den    = prod_q.den;
    seed_d.lx.neg = prod_q.neg_x;
    seed_d.lx.ovf = (top_x >= prod_q.den);
    seed_d.lx.rem = seed_d.lx.ovf ? '0 : top_x;
    seed_d.lx.dvd = prod_q.prod_x[QUO_W-1:0];
    seed_d.lx.quo = '0;
    seed_d.ly.neg = prod_q.neg_y;
    seed_d.ly.ovf = (top_y >= prod_q.den);
    seed_d.ly.rem = seed_d.ly.ovf ? '0 : top_y;
    seed_d.ly.dvd = prod_q.prod_y[QUO_W-1:0];
    seed_d.ly.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
      seed_v_q <= 1'b0;
    end else begin
      if (mag_rdy)  mag_v_q  <= valid_i;
      if (prod_rdy) prod_v_q <= mag_v_q;
      if (seed_rdy) seed_v_q <= prod_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mag_rdy && valid_i)   mag_q  <= mag_d;
    if (prod_rdy && mag_v_q)  prod_q <= prod_d;
    if (seed_rdy && prod_v_q) seed_q <= seed_d;
  end

  assign valid_o = seed_v_q;
  assign word_o  = seed_q;

endmodule

// ===== sv/ppc_cell.sv =====
// ---------------------------------------------------------------------------
// ppc_cell
// One restoring division step for both axes, producing one quotient bit.
// ---------------------------------------------------------------------------
module ppc_cell import ppc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  ppc_word_t word_i,
  output logic      valid_o,
  input  logic      ready_i,
  output ppc_word_t word_o
);

  logic      valid_q;
  ppc_word_t word_d, word_q;

  function automatic ppc_lane_t div_step(ppc_lane_t l, logic [DEN_W-1:0] den);
    logic [DEN_W:0]   trial;
    logic [DEN_W+1:0] diff;
    ppc_lane_t        r;
    trial = {l.rem, l.dvd[QUO_W-1]};
    diff  = {1'b0, trial} - {2'b00, den};
    r     = l;
    r.dvd = {l.dvd[QUO_W-2:0], 1'b0};
    if (!diff[DEN_W+1]) begin
      r.rem = diff[DEN_W-1:0];
      r.quo = {l.quo[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = trial[DEN_W-1:0];
      r.quo = {l.quo[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    word_d    = word_i;
    word_d.lx = div_step(word_i.lx, word_i.den);
    word_d.ly = div_step(word_i.ly, word_i.den);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== sv/ppc_finish.sv =====
// ---------------------------------------------------------------------------
// ppc_finish
// Adds the screen centre, tests the guard band and truncates to pixels.
// ---------------------------------------------------------------------------
module ppc_finish import ppc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  ppc_word_t                word_i,
  input  logic [WIN_W-1:0]         win_w_i,
  input  logic [WIN_W-1:0]         win_h_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [OUT_W-1:0]  screen_x_o,
  output logic signed [OUT_W-1:0]  screen_y_o,
  output logic                     visible_o
);

  logic                    sum_v_q, out_v_q, sum_rdy, out_rdy;
  logic signed [SUM_W-1:0] cen_x, cen_y, off_x, off_y, sx_d, sy_d, sx_q, sy_q;
  logic signed [SUM_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic                    shown_d, shown_q;
  logic signed [SUM_W-1:0] abs_x, abs_y;
  logic signed [SUM_W-1:0] px, py;
  logic signed [OUT_W-1:0] scr_x_q, scr_y_q;
  logic                    vis_q;

  assign out_rdy = !out_v_q || ready_i;
  assign sum_rdy = !sum_v_q || out_rdy;
  assign ready_o = sum_rdy;

  always_comb begin
    cen_x = $signed({15'd0, win_w_i[WIN_W-1:1], {FRAC_W{1'b0}}});
    cen_y = $signed({15'd0, win_h_i[WIN_W-1:1], {FRAC_W{1'b0}}});
    off_x = $signed({3'b000, word_i.lx.quo[SAT_BIT-1:0]});
    off_y = $signed({3'b000, word_i.ly.quo[SAT_BIT-1:0]});
    sx_d  = word_i.lx.neg ? (cen_x - off_x) : (cen_x + off_x);
    sy_d  = word_i.ly.neg ? (cen_y + off_y) : (cen_y - off_y);
    lo_x  = -$signed({14'd0, win_w_i, {FRAC_W{1'b0}}});
    hi_x  = $signed({13'd0, win_w_i, {(FRAC_W+1){1'b0}}});
    lo_y  = -$signed({14'd0, win_h_i, {FRAC_W{1'b0}}});
    hi_y  = $signed({13'd0, win_h_i, {(FRAC_W+1){1'b0}}});
    // Offsets from 2^40 up lie far outside any band and are hidden.
    shown_d = word_i.live && !word_i.lx.ovf && !word_i.ly.ovf
           && (word_i.lx.quo[QUO_W-1:SAT_BIT] == '0)
           && (word_i.ly.quo[QUO_W-1:SAT_BIT] == '0)
           && (sx_d >= lo_x) && (sx_d <= hi_x)
           && (sy_d >= lo_y) && (sy_d <= hi_y);
  end

  // Truncation toward zero works on the magnitude.
  always_comb begin
    abs_x = sx_q[SUM_W-1] ? -sx_q : sx_q;
    abs_y = sy_q[SUM_W-1] ? -sy_q : sy_q;
    px    = sx_q[SUM_W-1] ? -(abs_x >>> FRAC_W) : (abs_x >>> FRAC_W);
    py    = sy_q[SUM_W-1] ? -(abs_y >>> FRAC_W) : (abs_y >>> FRAC_W);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (sum_rdy) sum_v_q <= valid_i;
      if (out_rdy) out_v_q <= sum_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_rdy && valid_i) begin
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      shown_q <= shown_d;
    end
    if (out_rdy && sum_v_q) begin
      scr_x_q <= shown_q ? px[OUT_W-1:0] : '0;
      scr_y_q <= shown_q ? py[OUT_W-1:0] : '0;
      vis_q   <= shown_q;
    end
  end

  assign valid_o    = out_v_q;
  assign screen_x_o = scr_x_q;
  assign screen_y_o = scr_y_q;
  assign visible_o  = vis_q;

endmodule

// ===== sv/perspective_project_clip_unit.sv =====
// ---------------------------------------------------------------------------
// perspective_project_clip_unit
// Perspective projection of camera-space vertices with a guard-band clip.
// ---------------------------------------------------------------------------
// Throughput: one vertex word per cycle while the output is not stalled; each of
// the 42 division cells finishes one quotient bit and passes the word on.
// Reset: rst_ni is asynchronous and active low; it empties every stage and
// loads the reset window size and focal factors.
// ---------------------------------------------------------------------------
module perspective_project_clip_unit import ppc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ppc_vtx_if.sink           vtx_i,
  ppc_pix_if.source         pix_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // Configuration registers. The user must change them only while the pipeline is
  // empty (the block does not enforce it); the back end reads the window size straight from them.
  logic [WIN_W-1:0]   win_w_q, win_h_q;
  logic [FOCAL_W-1:0] focal_x_q, focal_y_q;
  logic               cfg_wr;
  ppc_reg_e           reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = ppc_reg_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_w_q   <= WIN_W_RST;
      win_h_q   <= WIN_H_RST;
      focal_x_q <= FOCAL_X_RST;
      focal_y_q <= FOCAL_Y_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_WIN_WIDTH:  win_w_q   <= pwdata[WIN_W-1:0];
        REG_WIN_HEIGHT: win_h_q   <= pwdata[WIN_W-1:0];
        REG_FOCAL_X:    focal_x_q <= pwdata[FOCAL_W-1:0];
        REG_FOCAL_Y:    focal_y_q <= pwdata[FOCAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WIN_WIDTH:  prdata = DATA_W'(win_w_q);
      REG_WIN_HEIGHT: prdata = DATA_W'(win_h_q);
      REG_FOCAL_X:    prdata = DATA_W'(focal_x_q);
      REG_FOCAL_Y:    prdata = DATA_W'(focal_y_q);
      default:        prdata = '0;
    endcase
  end

  // The row of division cells. Word k leaves cell k-1 and enters cell k;
  // word 0 comes from the front end with the remainders seeded.
  ppc_word_t cell_word  [QUO_W+1];
  logic      cell_valid [QUO_W+1];
  logic      cell_ready [QUO_W+1];

  ppc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (vtx_i.valid),
    .ready_o   (vtx_i.ready),
    .pos_x_i   (vtx_i.pos_x),
    .pos_y_i   (vtx_i.pos_y),
    .pos_z_i   (vtx_i.pos_z),
    .focal_x_i (focal_x_q),
    .focal_y_i (focal_y_q),
    .valid_o   (cell_valid[0]),
    .ready_i   (cell_ready[0]),
    .word_o    (cell_word[0])
  );

  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    ppc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_valid[k]),
      .ready_o (cell_ready[k]),
      .word_i  (cell_word[k]),
      .valid_o (cell_valid[k+1]),
      .ready_i (cell_ready[k+1]),
      .word_o  (cell_word[k+1])
    );
  end

  // Centre offset, band test and pixel truncation; its final register holds
  // the pixel word while the stages before it keep filling their gaps.
  ppc_finish u_finish (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (cell_valid[QUO_W]),
    .ready_o    (cell_ready[QUO_W]),
    .word_i     (cell_word[QUO_W]),
    .win_w_i    (win_w_q),
    .win_h_i    (win_h_q),
    .valid_o    (pix_o.valid),
    .ready_i    (pix_o.ready),
    .screen_x_o (pix_o.screen_x),
    .screen_y_o (pix_o.screen_y),
    .visible_o  (pix_o.visible)
  );

endmodule

// ===== sv/ppc_checker.sv =====
// ---------------------------------------------------------------------------
// ppc_checker
// Port-level checks on the pixel channel of the projection unit.
// ---------------------------------------------------------------------------
module ppc_checker import ppc_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    valid_i,
  input logic                    ready_i,
  input logic signed [OUT_W-1:0] screen_x_i,
  input logic signed [OUT_W-1:0] screen_y_i,
  input logic                    visible_i
);

  // A stalled pixel word stays and keeps its contents.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(screen_x_i) && $stable(screen_y_i)
                            && $stable(visible_i))
    else $error("pixel word changed while stalled");

  // A hidden point always reports the origin.
  a_hidden_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !visible_i |-> (screen_x_i == '0) && (screen_y_i == '0))
    else $error("hidden point with non-zero coordinates");

  // Reset empties the pipeline, so nothing is offered in the cycle after it.
  a_reset_empty : assert property (@(posedge clk_i)
    !rst_ni |=> !valid_i)
    else $error("pixel word offered during reset");

  // No pixel word is offered right after reset ends.
  a_fill_gap : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> ##1 !valid_i)
    else $error("pixel word too soon after reset");

endmodule

bind perspective_project_clip_unit ppc_checker u_ppc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .valid_i    (pix_o.valid),
  .ready_i    (pix_o.ready),
  .screen_x_i (pix_o.screen_x),
  .screen_y_i (pix_o.screen_y),
  .visible_i  (pix_o.visible)
);

// ===== test/perspective_project_clip_unit_tb.sv =====
// ---------------------------------------------------------------------------
// perspective_project_clip_unit_tb
// Self-checking bench for the perspective projection and guard-band clip.
// A directed table of vertex words comes first. Random vertex words follow
// under several window and focal settings, written over the register port.
// Every pixel word is compared with a typed value or a local fixed-point projection.
// ---------------------------------------------------------------------------
module perspective_project_clip_unit_tb;
  import ppc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The settle time is longer than the pipeline latency, so that a stray pixel
  // word after the last expected one is still caught.
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned PHASE_ITEMS   = 235;
  localparam longint      TIMEOUT_NS    = 25_000_000;
  localparam logic [63:0] QUO_SAT       = 64'd1 << SAT_BIT;

  // One pixel word as the block presents it.
  typedef struct packed {
    logic signed [OUT_W-1:0] screen_x;
    logic signed [OUT_W-1:0] screen_y;
    logic                    visible;
  } pix_word_t;

  // One row of the directed table. Where known_pix is set, the expected pixel
  // word is written into the row; otherwise the projection below supplies it.
  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic             known_pix;
    pix_word_t        pix;
  } vtx_row_t;

  localparam pix_word_t HIDDEN = '0;
  localparam pix_word_t CENTRE = '{15'sd400, 15'sd300, 1'b1};

  // The typed rows assume the reset settings: an 800 by 600 window with
  // focal factors of 400.0 and 300.0.
  vtx_row_t directed_rows [18] = '{
    // Depth zero, negative depth and the most negative depth are all hidden.
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, HIDDEN},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, HIDDEN},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, HIDDEN},
    // A point on the optical axis lands on the centre at any depth.
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b1, CENTRE},
    '{32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, CENTRE},
    // Largest lateral offsets over the smallest depth saturate the quotient.
    '{32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001, 1'b1, HIDDEN},
    '{32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 1'b1, HIDDEN},
    // Huge but unsaturated offset, far above the band.
    '{32'h0000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1'b1, HIDDEN},
    // Most negative x over the deepest depth.
    '{32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, HIDDEN},
    // Exactly on each edge of the guard band, and one step beyond each x edge.
    '{32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, HIDDEN},
    '{32'h0003_0001, 32'h0000_0000, 32'h0001_0000, 1'b0, HIDDEN},
    '{32'hFFFD_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, HIDDEN},
    '{32'hFFFC_FFFF, 32'h0000_0000, 32'h0001_0000, 1'b0, HIDDEN},
    '{32'h0000_0000, 32'h0003_0000, 32'h0001_0000, 1'b0, HIDDEN},
    '{32'h0000_0000, 32'hFFFD_0000, 32'h0001_0000, 1'b0, HIDDEN},
    // Negative fractional column, which must truncate toward zero.
    '{32'hFFFD_0001, 32'h0000_0001, 32'h0001_0000, 1'b0, HIDDEN},
    // Smallest magnitudes of either sign.
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, HIDDEN},
    '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, HIDDEN}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ppc_vtx_if vtx_bus ();
  ppc_pix_if pix_bus ();

  perspective_project_clip_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vtx_i   (vtx_bus),
    .pix_o   (pix_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Local copy of the registers, updated as each write completes.
  logic [WIN_W-1:0]   win_w = WIN_W_RST;
  logic [WIN_W-1:0]   win_h = WIN_H_RST;
  logic [FOCAL_W-1:0] foc_x = FOCAL_X_RST;
  logic [FOCAL_W-1:0] foc_y = FOCAL_Y_RST;

  pix_word_t   pending_pix [$];
  int unsigned fault_count   = 0;
  bit          steady_flow   = 1'b0;  // no idling on either side while set
  bit          hold_off_req  = 1'b0;  // asks the receiver for one long stall

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Projection
  // ---------------------------------------------------------------------------

  // Signed Q16.16 offset focal * pos / depth. The magnitude is divided exactly
  // and truncated, saturated at 2^40, and then given the sign of the position.
  function automatic longint signed lens_offset(logic [FOCAL_W-1:0] focal,
                                                logic signed [POS_W-1:0] pos,
                                                logic signed [POS_W-1:0] depth);
    logic [63:0] mag;
    logic [63:0] quo;
    mag = (pos < 0) ? 64'(-longint'(pos)) : 64'(longint'(pos));
    quo = (64'(focal) * mag) / 64'(longint'(depth));
    if (quo > QUO_SAT) quo = QUO_SAT;
    return (pos < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic longint signed to_pixels(longint signed v);
    return (v >= 0) ? (v >>> FRAC_W) : -((-v) >>> FRAC_W);
  endfunction

  function automatic pix_word_t project_vertex(logic signed [POS_W-1:0] px,
                                               logic signed [POS_W-1:0] py,
                                               logic signed [POS_W-1:0] pz);
    longint signed half_w, half_h, wq, hq, sx, sy;
    pix_word_t     r;
    r = HIDDEN;
    if (pz <= 0) return r;
    half_w = win_w >> 1;
    half_h = win_h >> 1;
    wq     = win_w;
    hq     = win_h;
    wq     = wq <<< FRAC_W;
    hq     = hq <<< FRAC_W;
    sx     = (half_w <<< FRAC_W) + lens_offset(foc_x, px, pz);
    sy     = (half_h <<< FRAC_W) - lens_offset(foc_y, py, pz);
    // The band test works on the exact Q16.16 sums, before truncation.
    if (sx >= -wq && sx <= 2 * wq && sy >= -hq && sy <= 2 * hq) begin
      r.screen_x = OUT_W'(to_pixels(sx));
      r.screen_y = OUT_W'(to_pixels(sy));
      r.visible  = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // A lateral coordinate. Most are a random fraction (below four) of the
  // depth, which keeps the projected point near the screen and its guard
  // band; the rest are raw bit patterns or random magnitudes.
  function automatic logic [POS_W-1:0] lateral(logic [POS_W-1:0] depth);
    longint      mag;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      mag = (longint'(depth) * $urandom_range(0, 16383)) >>> 12;
      if (mag > 32'h7FFF_FFFF) mag = 32'h7FFF_FFFF;
    end else if (pick < 8) begin
      return $urandom;
    end else begin
      mag = $urandom >> $urandom_range(0, 31);
    end
    return $urandom_range(0, 1) ? POS_W'(-mag) : POS_W'(mag);
  endfunction

  task automatic make_vertex(output logic [POS_W-1:0] x, output logic [POS_W-1:0] y,
                             output logic [POS_W-1:0] z);
    logic [POS_W-1:0] base;
    if ($urandom_range(0, 99) < 8) begin
      case ($urandom_range(0, 2))
        0: begin
          z = '0;
        end
        1: begin
          z = 32'hFFFF_FFFF;
        end
        default: begin
          z = $urandom | 32'h8000_0000;
        end
      endcase
    end else begin
      // Spread the depth over every magnitude, not just the large ones.
      z = $urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 30);
      if (z == '0) z = 32'd1;
    end
    base = (z[POS_W-1] || z == '0) ? POS_W'($urandom_range(1, 32'h0010_0000)) : z;
    x = lateral(base);
    y = lateral(base);
  endtask

  // ---------------------------------------------------------------------------
  // Vertex sender
  // ---------------------------------------------------------------------------

  // Offers one vertex word and waits until it is taken. The expectation is
  // queued at the accepting edge. Between words the sender may idle, with
  // junk on the payload while valid is low.
  task automatic send_vertex(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                             logic [POS_W-1:0] z, logic known_pix, pix_word_t pix);
    int unsigned gap;
    @(negedge clk_i);
    vtx_bus.valid <= 1'b1;
    vtx_bus.pos_x <= x;
    vtx_bus.pos_y <= y;
    vtx_bus.pos_z <= z;
    @(posedge clk_i);
    while (!vtx_bus.ready) @(posedge clk_i);
    pending_pix.push_back(known_pix ? pix : project_vertex(x, y, z));
    if (!steady_flow && $urandom_range(0, 2) == 0) begin
      gap = idle_len();
      @(negedge clk_i);
      vtx_bus.valid <= 1'b0;
      vtx_bus.pos_x <= $urandom;
      vtx_bus.pos_y <= $urandom;
      vtx_bus.pos_z <= $urandom;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_random(int unsigned count);
    logic [POS_W-1:0] x, y, z;
    repeat (count) begin
      make_vertex(x, y, z);
      send_vertex(x, y, z, 1'b0, HIDDEN);
    end
  endtask

  // Stops offering and waits for every outstanding pixel word, then lets the
  // pipeline settle so that nothing is left in flight.
  task automatic drain();
    @(negedge clk_i);
    vtx_bus.valid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------

  // Writes one register, reads it back and updates the local copy. Only
  // called while the pipeline is empty.
  task automatic write_reg(ppc_reg_e idx, logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] held;
    held = value;
    if (idx == REG_WIN_WIDTH || idx == REG_WIN_HEIGHT) held = DATA_W'(value[WIN_W-1:0]);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_WIN_WIDTH: begin
        win_w = value[WIN_W-1:0];
      end
      REG_WIN_HEIGHT: begin
        win_h = value[WIN_W-1:0];
      end
      REG_FOCAL_X: begin
        foc_x = value;
      end
      default: begin
        foc_y = value;
      end
    endcase
    // Read back through a second transfer on the same address.
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== held) begin
      $error("read back of %s: expected 0x%08h, actual 0x%08h", idx.name(), held, prdata);
      fault_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_settings(logic [DATA_W-1:0] w, logic [DATA_W-1:0] h,
                                logic [DATA_W-1:0] fx, logic [DATA_W-1:0] fy);
    drain();
    write_reg(REG_WIN_WIDTH, w);
    write_reg(REG_WIN_HEIGHT, h);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
  endtask

  // ---------------------------------------------------------------------------
  // Pixel receiver
  // ---------------------------------------------------------------------------

  // Ready changes at the falling edge. Short and long stalls come at random,
  // except while steady flow is asked for. A hold-off request lowers ready
  // for a long, fixed stretch so that the pipeline fills and stalls its input.
  initial begin : pix_receiver
    int unsigned stall_left;
    stall_left    = 0;
    pix_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        pix_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_off_req = 1'b0;
        pix_bus.ready <= 1'b1;
      end else if (stall_left > 0 && !steady_flow) begin
        pix_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        pix_bus.ready <= 1'b1;
        stall_left = 0;
        if (!steady_flow && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // Every accepted pixel word is matched against the oldest expectation.
  always @(posedge clk_i) begin : pix_check
    pix_word_t want;
    if (rst_ni && pix_bus.valid && pix_bus.ready) begin
      if (pending_pix.size() == 0) begin
        $error("pixel word with none expected: screen_x %0d screen_y %0d visible %0b",
               pix_bus.screen_x, pix_bus.screen_y, pix_bus.visible);
        fault_count++;
      end else begin
        want = pending_pix.pop_front();
        if (pix_bus.screen_x !== want.screen_x) begin
          $error("screen_x: expected %0d, actual %0d", want.screen_x, pix_bus.screen_x);
          fault_count++;
        end
        if (pix_bus.screen_y !== want.screen_y) begin
          $error("screen_y: expected %0d, actual %0d", want.screen_y, pix_bus.screen_y);
          fault_count++;
        end
        if (pix_bus.visible !== want.visible) begin
          $error("visible: expected %0b, actual %0b", want.visible, pix_bus.visible);
          fault_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    vtx_bus.valid = 1'b0;
    vtx_bus.pos_x = '0;
    vtx_bus.pos_y = '0;
    vtx_bus.pos_z = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table under the reset settings.
    foreach (directed_rows[i]) begin
      send_vertex(directed_rows[i].pos_x, directed_rows[i].pos_y, directed_rows[i].pos_z,
                  directed_rows[i].known_pix, directed_rows[i].pix);
    end
    send_random(PHASE_ITEMS);

    // Largest window and focal factors. The width write carries junk above
    // the thirteen register bits, which must be dropped.
    apply_settings(32'hFFFF_FFFF, 32'd8191, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_random(PHASE_ITEMS);

    // All zero: every point in front of the camera maps to the origin and the
    // band shrinks to that single pixel.
    apply_settings(32'd0, 32'd0, 32'd0, 32'd0);
    send_random(PHASE_ITEMS);

    // Smallest non-zero settings, with a full pause of the sender half way so
    // that the pipeline runs empty in the middle of a phase.
    apply_settings(32'd1, 32'd1, 32'd1, 32'd1);
    send_random(PHASE_ITEMS / 2);
    drain();
    send_random(PHASE_ITEMS - PHASE_ITEMS / 2);

    // Largest nominal window, random focal factors; the first half runs with
    // no idling on either side.
    apply_settings(32'd4096, 32'd4096, $urandom, $urandom);
    steady_flow = 1'b1;
    send_random(PHASE_ITEMS / 2);
    steady_flow = 1'b0;
    send_random(PHASE_ITEMS - PHASE_ITEMS / 2);

    // Random window and scaled-down focal factors.
    apply_settings($urandom_range(1, 4096), $urandom_range(1, 4096),
                   $urandom >> $urandom_range(4, 12), $urandom >> $urandom_range(4, 12));
    send_random(PHASE_ITEMS);

    // A ninety degree field of view on a wide screen. The receiver holds off
    // for a long stretch while the sender keeps offering back to back.
    apply_settings(32'd1920, 32'd1080, 32'd62914560, 32'd35389440);
    steady_flow  = 1'b1;
    hold_off_req = 1'b1;
    send_random(PHASE_ITEMS);
    steady_flow  = 1'b0;

    // Back to the reset values, written explicitly.
    apply_settings(32'(WIN_W_RST), 32'(WIN_H_RST), FOCAL_X_RST, FOCAL_Y_RST);
    send_random(PHASE_ITEMS);

    drain();
    if (fault_count == 0) begin
      $display("perspective_project_clip_unit verification clean");
    end else begin
      $display("perspective_project_clip_unit verification failed");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("perspective_project_clip_unit verification failed");
    $finish;
  end

endmodule
